// ----- hw/rtl/skf_pkg.sv -----
package skf_pkg;

  localparam int CHANNELS  = 9;
  localparam int FRAC_BITS = 16;
  localparam int CH_W      = 4;
  localparam int IDX_W     = $clog2(CHANNELS);

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_H = 2'd1;
  localparam logic [1:0] REG_Q = 2'd2;
  localparam logic [1:0] REG_R = 2'd3;

  localparam logic signed [31:0] ONE_Q    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] EST2_RST = 32'((((64'd98) << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0]        R_RST    = 31'(64'd50 << FRAC_BITS);

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_out;
    logic signed [31:0] estimate;
    logic [30:0]        variance;
  } out_item_t;

  // floor shift of an exact product
  function automatic logic signed [64:0] fshift(input logic signed [64:0] p);
    fshift = p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [30:0] sat31u(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat31u = 31'h7fffffff;
    else if (v < 66'sd0) sat31u = '0;
    else sat31u = v[30:0];
  endfunction

  function automatic logic signed [31:0] est_reset(input int i);
    if (i == 2) est_reset = EST2_RST;
    else if (i == 6) est_reset = ONE_Q;
    else est_reset = '0;
  endfunction

endpackage

// ----- hw/rtl/scalar_kalman_filter_bank.sv -----
// Scalar Kalman filter bank: one 1-D filter per sensor channel, Q16.16.
// Input channel (in_valid/in_ready, in_item): channel number and measurement.
// Output channel (out_valid/out_ready, out_item): channel, new estimate and
// variance; out-of-range channels return zeros and leave state alone.
// Config port: cfg_we/cfg_idx/cfg_data, 0=A 1=H 2=Q 3=R; user must write
// it when idle; the block itself does not enforce this. One item at a time:
// one memory read, ten steps through a single shared 32x32 multiplier
// (one per cycle outside the divide), a restoring divider for the gain (48
// quotient bits, one per cycle, plus a finish step) and a writeback state.
// An out-of-range channel answers in the cycle after accept. The next item
// is accepted in the cycle after the result is taken.
// Estimates and variances live in a 1-read/1-write memory; per-channel
// valid bits make never-written entries read their reset values, so no
// clearing pass is needed after reset.
// Reset (synchronous, rst_n low) returns registers to A=H=Q=1.0, R=50.0,
// clears all valid bits and empties the output register.
// The result sits in an output register; while the receiver stalls the
// block finishes nothing more and in_ready stays low until it is taken.
module scalar_kalman_filter_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skf_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output skf_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_OUT  = 4'd5;

  logic signed [31:0] a_r, h_r;
  logic [30:0]        q_r, rn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= skf_pkg::ONE_Q;
      h_r  <= skf_pkg::ONE_Q;
      q_r  <= 31'(skf_pkg::ONE_Q);
      rn_r <= skf_pkg::R_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        skf_pkg::REG_A: a_r  <= cfg_data;
        skf_pkg::REG_H: h_r  <= cfg_data;
        skf_pkg::REG_Q: q_r  <= cfg_data[30:0];
        skf_pkg::REG_R: rn_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // state memory: {estimate, variance}
  logic [63:0] mem [skf_pkg::CHANNELS];
  logic [63:0] rd_r;
  logic [skf_pkg::CHANNELS-1:0] vld_r;
  logic [skf_pkg::IDX_W-1:0] idx_r;

  logic [3:0]  state_r;
  logic [3:0]  step_r;
  logic [5:0]  dcnt_r;
  logic [3:0]  ch_r;
  logic signed [31:0] z_r;

  logic signed [31:0] x_r, p_r, aa_r, hh_r, xp_r, pp_r, hp_r, hx_r, k_r, hk_r;
  logic [30:0] d_r;
  logic signed [31:0] xn_r;
  logic [30:0] pn_r;

  // divider: |hp|<<16 / d, restoring
  logic [47:0] dq_r;
  logic [31:0] drem_r;
  logic        dneg_r;

  // shared multiplier operands
  logic signed [31:0] m_a, m_b;
  logic signed [64:0] m_p;
  logic signed [64:0] m_f;

  logic signed [31:0] sat_innov, f_val;
  assign sat_innov = skf_pkg::sat32(66'(z_r) - 66'(hx_r));
  assign f_val = skf_pkg::sat32(66'(skf_pkg::ONE_Q) - 66'(hk_r));

  always_comb begin
    m_a = a_r;
    m_b = a_r;
    case (step_r)
      4'd0: begin m_a = a_r;  m_b = a_r;  end
      4'd1: begin m_a = h_r;  m_b = h_r;  end
      4'd2: begin m_a = a_r;  m_b = x_r;  end
      4'd3: begin m_a = aa_r; m_b = p_r;  end
      4'd4: begin m_a = h_r;  m_b = pp_r; end
      4'd5: begin m_a = hh_r; m_b = pp_r; end
      4'd6: begin m_a = h_r;  m_b = xp_r; end
      4'd7: begin m_a = k_r;  m_b = sat_innov; end
      4'd8: begin m_a = h_r;  m_b = k_r;  end
      4'd9: begin m_a = f_val; m_b = pp_r; end
      default: ;
    endcase
    m_p = 65'(m_a) * 65'(m_b);
    m_f = skf_pkg::fshift(m_p);
  end

  logic [32:0] dsub;
  assign dsub = {drem_r, dq_r[47]} - {2'b0, d_r};

  logic signed [65:0] kq;
  assign kq = dneg_r ? -66'($signed({18'b0, dq_r})) : 66'($signed({18'b0, dq_r}));

  logic in_range;
  assign in_range = in_item.channel < 4'(skf_pkg::CHANNELS);

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r  <= in_item.channel;
      z_r   <= in_item.measurement;
      idx_r <= in_item.channel[skf_pkg::IDX_W-1:0];
      rd_r  <= mem[in_item.channel[skf_pkg::IDX_W-1:0]];
    end
    if (state_r == S_WB) mem[idx_r] <= {xn_r, 1'b0, pn_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vld_r     <= '0;
      out_valid <= 1'b0;
      step_r    <= '0;
      dcnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          if (in_range) state_r <= S_RD;
          else begin
            out_item  <= '{channel_out: in_item.channel, estimate: '0, variance: '0};
            out_valid <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_RD: begin
          x_r <= vld_r[idx_r] ? rd_r[63:32] : skf_pkg::est_reset(int'(idx_r));
          p_r <= vld_r[idx_r] ? rd_r[31:0]  : skf_pkg::ONE_Q;
          step_r  <= 4'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd0: aa_r <= 32'(skf_pkg::sat31u(66'(m_f)));
            4'd1: hh_r <= 32'(skf_pkg::sat31u(66'(m_f)));
            4'd2: xp_r <= skf_pkg::sat32(66'(m_f));
            4'd3: pp_r <= 32'(skf_pkg::sat31u(66'(m_f) + 66'(q_r)));
            4'd4: hp_r <= skf_pkg::sat32(66'(m_f));
            4'd5: begin
              d_r <= skf_pkg::sat31u(66'(m_f) + 66'(rn_r));
              dneg_r <= hp_r[31];
              dq_r   <= {(hp_r[31] ? 32'(-33'(hp_r)) : hp_r), 16'b0};
              drem_r <= '0;
              dcnt_r <= '0;
              state_r <= S_DIV;
            end
            4'd6: hx_r <= skf_pkg::sat32(66'(m_f));
            4'd7: xn_r <= skf_pkg::sat32(66'(xp_r) + 66'(m_f));
            4'd8: hk_r <= skf_pkg::sat32(66'(m_f));
            default: begin
              pn_r    <= skf_pkg::sat31u(66'(m_f));
              state_r <= S_WB;
            end
          endcase
        end
        S_DIV: begin
          if (dcnt_r == 6'd48) begin
            k_r     <= (d_r == '0) ? '0 : skf_pkg::sat32(kq);
            state_r <= S_MUL;
          end else begin
            dcnt_r <= dcnt_r + 6'd1;
            if (!dsub[32]) begin
              drem_r <= dsub[31:0];
              dq_r   <= {dq_r[46:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dq_r[47]};
              dq_r   <= {dq_r[46:0], 1'b0};
            end
          end
        end
        S_WB: begin
          vld_r[idx_r] <= 1'b1;
          out_item  <= '{channel_out: ch_r, estimate: xn_r, variance: pn_r};
          out_valid <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUT)) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_wb_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_valid) else $error("writeback without result");

endmodule

// ----- sim/tb_scalar_kalman_filter_bank.sv -----
`timescale 1ns / 100ps

module tb_scalar_kalman_filter_bank;

  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;
  localparam int     LATENCY = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  skf_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  skf_pkg::out_item_t out_item;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  scalar_kalman_filter_bank dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor state: our own copy of the filter bank and its gains.
  longint filt_est[skf_pkg::CHANNELS];
  longint filt_var[skf_pkg::CHANNELS];
  longint gain_a, gain_h, noise_q, noise_r;

  skf_pkg::out_item_t expected_q[$];
  int        n_items;
  int        n_results;
  int        n_mismatch;
  int        n_empty_ch;
  bit        hold_off;   // receiver long stall request
  bit        bursty;     // enable random gaps on the input side

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far above the time for about 1450 items plus worst stalls.
  initial begin
    #(12 * 2000000);
    $display("tb: failure");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact product, then floor shift (>>> on signed is floor).
  function automatic longint qmul(longint v, longint w);
    longint p;
    p = v * w;
    return p >>> skf_pkg::FRAC_BITS;
  endfunction

  function automatic void filters_reset();
    for (int i = 0; i < skf_pkg::CHANNELS; i++) begin
      filt_est[i] = 0;
      filt_var[i] = 64'sd1 << skf_pkg::FRAC_BITS;
    end
    filt_est[2] = ((64'sd98 << skf_pkg::FRAC_BITS) + 5) / 10;
    filt_est[6] = 64'sd1 << skf_pkg::FRAC_BITS;
    gain_a  = 64'sd1 << skf_pkg::FRAC_BITS;
    gain_h  = 64'sd1 << skf_pkg::FRAC_BITS;
    noise_q = 64'sd1 << skf_pkg::FRAC_BITS;
    noise_r = 64'sd50 << skf_pkg::FRAC_BITS;
  endfunction

  // One Kalman update for the item's channel.
  function automatic skf_pkg::out_item_t kalman_update(skf_pkg::in_item_t it);
    skf_pkg::out_item_t r;
    longint z, aa, hh, xp, pp, hp, d, k, hx, innov, xn, hk, f, pn;
    int ch;
    ch = it.channel;
    r.channel_out = it.channel;
    if (ch >= skf_pkg::CHANNELS) begin
      r.estimate = '0;
      r.variance = '0;
      return r;
    end
    z     = longint'(it.measurement);
    aa    = clamp(qmul(gain_a, gain_a), 0, SAT_HI);
    hh    = clamp(qmul(gain_h, gain_h), 0, SAT_HI);
    xp    = clamp(qmul(gain_a, filt_est[ch]), SAT_LO, SAT_HI);
    pp    = clamp(qmul(aa, filt_var[ch]) + noise_q, 0, SAT_HI);
    hp    = clamp(qmul(gain_h, pp), SAT_LO, SAT_HI);
    d     = clamp(qmul(hh, pp) + noise_r, 0, SAT_HI);
    // zero denominator gives zero gain
    k     = (d == 0) ? 0 :
            clamp((hp * (64'sd1 << skf_pkg::FRAC_BITS)) / d, SAT_LO, SAT_HI);
    hx    = clamp(qmul(gain_h, xp), SAT_LO, SAT_HI);
    innov = clamp(z - hx, SAT_LO, SAT_HI);
    xn    = clamp(xp + qmul(k, innov), SAT_LO, SAT_HI);
    hk    = clamp(qmul(gain_h, k), SAT_LO, SAT_HI);
    f     = clamp((64'sd1 << skf_pkg::FRAC_BITS) - hk, SAT_LO, SAT_HI);
    pn    = clamp(qmul(f, pp), 0, SAT_HI);
    filt_est[ch] = xn;
    filt_var[ch] = pn;
    r.estimate = xn[31:0];
    r.variance = pn[30:0];
    return r;
  endfunction

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result ch=%0d est=%0d var=%0d",
                   out_item.channel_out, out_item.estimate, out_item.variance);
      end else begin
        skf_pkg::out_item_t e;
        e = expected_q.pop_front();
        n_results++;
        if (out_item.channel_out !== e.channel_out || out_item.estimate !== e.estimate ||
            out_item.variance !== e.variance) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp ch=%0d est=%0d var=%0d / got ch=%0d est=%0d var=%0d",
                     e.channel_out, e.estimate, e.variance, out_item.channel_out,
                     out_item.estimate, out_item.variance);
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, sometimes long; a hold-off
  // request blocks it for a counted stretch.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ?
            (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4)) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Send one item; the expectation is queued when it is accepted.
  task automatic send_item(logic [3:0] ch, logic [31:0] meas);
    skf_pkg::in_item_t it;
    int gap;
    if (bursty && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.channel     = ch;
    it.measurement = meas;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(kalman_update(it));
    n_items++;
    if (ch >= skf_pkg::CHANNELS) n_empty_ch++;
  endtask

  // Wait for all results, then let the block settle before a config write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      skf_pkg::REG_A: gain_a  = longint'($signed(val));
      skf_pkg::REG_H: gain_h  = longint'($signed(val));
      skf_pkg::REG_Q: noise_q = longint'(val[30:0]);
      skf_pkg::REG_R: noise_r = longint'(val[30:0]);
    endcase
  endtask

  task automatic set_gains(logic [31:0] a, logic [31:0] h, logic [31:0] q, logic [31:0] r);
    drain();
    write_reg(skf_pkg::REG_A, a);
    write_reg(skf_pkg::REG_H, h);
    write_reg(skf_pkg::REG_Q, q);
    write_reg(skf_pkg::REG_R, r);
  endtask

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    endcase
  endfunction

  // Directed: reset presets, field extremes, every channel, bad channels.
  task automatic test_directed();
    send_item(4'd2, 32'sd10 << 16);
    send_item(4'd6, 32'sd1 << 16);
    send_item(4'd0, 32'h7fffffff);
    send_item(4'd1, 32'h80000000);
    send_item(4'd0, 32'hffffffff);
    send_item(4'd8, 32'h0);
    send_item(4'd9, 32'h12345678);
    send_item(4'd15, 32'hffffffff);
    for (int c = 0; c < skf_pkg::CHANNELS; c++) send_item(c[3:0], 32'h5555aaaa);
  endtask

  // Zero denominator: H=0 and R=0 gives a zero gain; then saturating gains.
  task automatic test_special_gains();
    set_gains(32'h00010000, 32'h0, 32'h0, 32'h0);
    for (int c = 0; c < 4; c++) send_item(c[3:0], rand_meas());
    set_gains(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    for (int c = 0; c < 6; c++) send_item(c[3:0], rand_meas());
    set_gains(32'h80000000, 32'h80000000, 32'h0, 32'h00000001);
    for (int c = 0; c < 6; c++) send_item(c[3:0], rand_meas());
  endtask

  // Random phases with a fresh configuration each, mostly realistic gains.
  task automatic test_random(int n);
    logic [31:0] a, h;
    bursty = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        a = $urandom; h = $urandom;
      end else begin
        a = $urandom_range(40000, 90000); h = $urandom_range(20000, 140000);
      end
      set_gains(a, h, (ph % 4 == 0) ? $urandom : $urandom_range(0, 300000),
                (ph == 5) ? 32'h0 : $urandom_range(0, 1 << 24));
      for (int i = 0; i < n / 8; i++)
        send_item(($urandom_range(0, 11) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8)), rand_meas());
    end
  endtask

  // Long receiver stall while the sender keeps offering items, then more items under a new configuration.
  task automatic test_backpressure();
    bursty = 1'b0;
    drain();
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_item(4'($urandom_range(0, 8)), rand_meas());
    drain();
    set_gains(32'h00010000, 32'h00010000, 32'h00010000, 32'd3276800);
    for (int i = 0; i < 20; i++) send_item(4'($urandom_range(0, 8)), rand_meas());
  endtask

  initial begin
    int wait_cnt;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = skf_pkg::REG_A;
    cfg_data = '0;
    hold_off = 1'b0;
    bursty   = 1'b0;
    n_items = 0; n_results = 0; n_mismatch = 0; n_empty_ch = 0;
    filters_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_special_gains();
    test_backpressure();
    test_random(1360);

    in_valid <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY) @(posedge clk);

    $display("run: %0d items sent, %0d results checked, %0d to unused channels",
             n_items, n_results, n_empty_ch);
    $display("covered: reset presets, zero gain, saturating gains, long stalls");
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
